// ===== rtl/cpad_pkg.sv =====
// cpad_pkg: shared widths and the control word that rides along the cell chain
// no dependencies
package cpad_pkg;

  localparam int VALUE_W = 32;
  localparam int COL_W   = 4;
  localparam int SUM_W   = 64;

  typedef struct packed {
    logic valid;
    logic last;
    logic drop;
  } cpad_ctl_t;

endpackage

// ===== rtl/cpad_in_if.sv =====
// cpad_in_if: input channel, one value word with its column and end-of-set mark
// depends on cpad_pkg
interface cpad_in_if;
  import cpad_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [COL_W-1:0]   column;
  logic               end_of_set;

  modport source (output valid, output value, output column, output end_of_set, input ready);
  modport sink (input valid, input value, input column, input end_of_set, output ready);
endinterface

// ===== rtl/cpad_out_if.sv =====
// cpad_out_if: result channel, saturated total and its two flags
// depends on cpad_pkg
interface cpad_out_if;
  import cpad_pkg::*;

  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] total;
  logic             sum_overflow;
  logic             capacity_exceeded;

  modport source (output valid, output total, output sum_overflow, output capacity_exceeded,
                  input ready);
  modport sink (input valid, input total, input sum_overflow, input capacity_exceeded,
                output ready);
endinterface

// ===== rtl/cpad_cell.sv =====
// cpad_cell: one row slot of the chain, holds row INDEX of every column
// reads its stored value, adds the absolute difference, stores the word in its row
// depends on cpad_pkg
module cpad_cell #(
  parameter int MAX_COLS = 16,
  parameter int INDEX    = 0,
  parameter int CW       = 4,
  parameter int FW       = 7
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  cpad_pkg::cpad_ctl_t         in_ctl,
  input  logic [cpad_pkg::VALUE_W-1:0] in_value,
  input  logic [CW-1:0]               in_col,
  input  logic [FW-1:0]               in_fill,
  input  logic [cpad_pkg::SUM_W-1:0]  in_sum,
  output cpad_pkg::cpad_ctl_t         out_ctl,
  output logic [cpad_pkg::VALUE_W-1:0] out_value,
  output logic [CW-1:0]               out_col,
  output logic [FW-1:0]               out_fill,
  output logic [cpad_pkg::SUM_W-1:0]  out_sum
);
  import cpad_pkg::*;

  localparam logic [FW-1:0] IDX = FW'(INDEX);

  logic [VALUE_W-1:0] mem [MAX_COLS];
  logic [VALUE_W-1:0] rd;

  cpad_ctl_t          a_ctl;
  logic [VALUE_W-1:0] a_value;
  logic [CW-1:0]      a_col;
  logic [FW-1:0]      a_fill;
  logic [SUM_W-1:0]   a_sum;

  logic               use_row;
  logic [VALUE_W-1:0] diff;
  logic [SUM_W-1:0]   sum_next;

  // row storage, read data registered
  always_ff @(posedge clk) begin
    if (adv) begin
      rd <= mem[in_col];
      if (in_ctl.valid && !in_ctl.drop && in_fill == IDX) begin
        mem[in_col] <= in_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl   <= '0;
      out_ctl <= '0;
    end else if (adv) begin
      a_ctl   <= in_ctl;
      out_ctl <= a_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_value   <= in_value;
      a_col     <= in_col;
      a_fill    <= in_fill;
      a_sum     <= in_sum;
      out_value <= a_value;
      out_col   <= a_col;
      out_fill  <= a_fill;
      out_sum   <= sum_next;
    end
  end

  always_comb begin
    use_row  = a_ctl.valid && !a_ctl.drop && (IDX < a_fill);
    diff     = (a_value >= rd) ? (a_value - rd) : (rd - a_value);
    sum_next = a_sum + (use_row ? {{(SUM_W-VALUE_W){1'b0}}, diff} : '0);
  end

endmodule

// ===== rtl/cpad_acc.sv =====
// cpad_acc: saturating running total at the end of the chain and the result register
// depends on cpad_pkg, cpad_out_if
module cpad_acc (
  input  logic                       clk,
  input  logic                       rst,
  input  cpad_pkg::cpad_ctl_t        in_ctl,
  input  logic [cpad_pkg::SUM_W-1:0] in_sum,
  output logic                       adv,
  cpad_out_if.source                 dout
);
  import cpad_pkg::*;

  logic [SUM_W-1:0] total;
  logic             ovf;
  logic             drp;

  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] total_next;
  logic             ovf_next;
  logic             drp_next;

  assign adv = !dout.valid || dout.ready;

  always_comb begin
    sum_wide   = {1'b0, total} + {1'b0, in_sum};
    total_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    ovf_next   = ovf || sum_wide[SUM_W];
    drp_next   = drp || in_ctl.drop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total      <= '0;
      ovf        <= 1'b0;
      drp        <= 1'b0;
      dout.valid <= 1'b0;
    end else begin
      if (adv && in_ctl.valid && in_ctl.last) begin
        dout.valid <= 1'b1;
      end else if (dout.ready) begin
        dout.valid <= 1'b0;
      end
      if (adv && in_ctl.valid) begin
        if (in_ctl.last) begin
          total <= '0;
          ovf   <= 1'b0;
          drp   <= 1'b0;
        end else begin
          total <= total_next;
          ovf   <= ovf_next;
          drp   <= drp_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_ctl.valid && in_ctl.last) begin
      dout.total             <= total_next;
      dout.sum_overflow      <= ovf_next;
      dout.capacity_exceeded <= drp_next;
    end
  end

endmodule

// ===== rtl/column_pairwise_abs_difference_sum_unit.sv =====
// channel | dir | word
// din     | in  | value[31:0], column[3:0], end_of_set
// dout    | out | total[63:0], sum_overflow, capacity_exceeded (end-of-set words only)
//
// one word accepted per cycle while the result register is free or being taken
// result of an end-of-set word passes the entry register, two registers per row cell
// and the result register
// a held result stalls the whole cell chain and drops din.ready
// synchronous reset clears column fills, totals and all valid bits; row storage is not cleared
// depends on cpad_pkg, cpad_in_if, cpad_out_if, cpad_cell, cpad_acc
module column_pairwise_abs_difference_sum_unit #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 16
) (
  input  logic       clk,
  input  logic       rst,
  cpad_in_if.sink    din,
  cpad_out_if.source dout
);
  import cpad_pkg::*;

  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int FW = $clog2(MAX_ROWS + 1);
  localparam logic [FW-1:0] FULL = FW'(MAX_ROWS);

  logic              adv;
  logic              accept;
  logic [CW+COL_W-1:0] col_wide;
  logic [CW-1:0]     col_idx;
  logic              in_range;
  logic [FW-1:0]     cur_fill;
  logic              drop;

  logic [FW-1:0]     fill [MAX_COLS];

  cpad_ctl_t          ctl_c   [MAX_ROWS+1];
  logic [VALUE_W-1:0] value_c [MAX_ROWS+1];
  logic [CW-1:0]      col_c   [MAX_ROWS+1];
  logic [FW-1:0]      fill_c  [MAX_ROWS+1];
  logic [SUM_W-1:0]   sum_c   [MAX_ROWS+1];

  assign din.ready = adv;
  assign accept    = din.valid && adv;

  always_comb begin
    col_wide = {{CW{1'b0}}, din.column};
    col_idx  = col_wide[CW-1:0];
    in_range = ({{(32-COL_W){1'b0}}, din.column} < 32'(MAX_COLS));
    cur_fill = fill[col_idx];
    drop     = !in_range || (cur_fill == FULL);
  end

  // per-column fill counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_COLS; i++) begin
        fill[i] <= '0;
      end
    end else if (accept) begin
      if (din.end_of_set) begin
        for (int i = 0; i < MAX_COLS; i++) begin
          fill[i] <= '0;
        end
      end else if (!drop) begin
        fill[col_idx] <= cur_fill + FW'(1);
      end
    end
  end

  // entry register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_c[0] <= '0;
    end else if (adv) begin
      ctl_c[0].valid <= din.valid;
      ctl_c[0].last  <= din.end_of_set;
      ctl_c[0].drop  <= drop;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      value_c[0] <= din.value;
      col_c[0]   <= col_idx;
      fill_c[0]  <= cur_fill;
    end
  end

  assign sum_c[0] = '0;

  for (genvar k = 0; k < MAX_ROWS; k++) begin : g_cell
    cpad_cell #(
      .MAX_COLS (MAX_COLS),
      .INDEX    (k),
      .CW       (CW),
      .FW       (FW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_ctl    (ctl_c[k]),
      .in_value  (value_c[k]),
      .in_col    (col_c[k]),
      .in_fill   (fill_c[k]),
      .in_sum    (sum_c[k]),
      .out_ctl   (ctl_c[k+1]),
      .out_value (value_c[k+1]),
      .out_col   (col_c[k+1]),
      .out_fill  (fill_c[k+1]),
      .out_sum   (sum_c[k+1])
    );
  end

  cpad_acc u_acc (
    .clk    (clk),
    .rst    (rst),
    .in_ctl (ctl_c[MAX_ROWS]),
    .in_sum (sum_c[MAX_ROWS]),
    .adv    (adv),
    .dout   (dout)
  );

endmodule

// ===== rtl/cpad_checker.sv =====
// cpad_checker: port-level checks on the pairwise difference sum unit
// depends on cpad_pkg; bound to column_pairwise_abs_difference_sum_unit
module cpad_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [cpad_pkg::SUM_W-1:0] total,
  input logic                       sum_overflow,
  input logic                       capacity_exceeded
);
  import cpad_pkg::*;

  // held result keeps its word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(total) && $stable(sum_overflow)
      && $stable(capacity_exceeded))
    else $error("result word changed while stalled");

  // a held result stalls the input side
  a_stall_in: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while result held");

  // saturation flag only with an all-ones total
  a_sat_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && sum_overflow |-> total == '1)
    else $error("overflow flagged without saturated total");

  // no result right after reset
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // ready follows the result register
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind column_pairwise_abs_difference_sum_unit cpad_checker u_cpad_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (din.valid),
  .in_ready          (din.ready),
  .out_valid         (dout.valid),
  .out_ready         (dout.ready),
  .total             (dout.total),
  .sum_overflow      (dout.sum_overflow),
  .capacity_exceeded (dout.capacity_exceeded)
);
